// ----- rtl/core/ipc_pkg.sv -----
// Shared types and constants for the integer partition counter.
package ipc_pkg;

  localparam int NUM_W       = 9;
  localparam int COUNT_W     = 50;
  localparam int MAX_N_DFLT  = 256;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic clr_we;
    logic clr_one;
    num_t clr_addr;
    logic issue;
    logic last;
    num_t ra;
    num_t rb;
  } seq_step_t;

endpackage

// ----- rtl/core/ipc_ram.sv -----
// Generic synchronous RAM: one write port, two registered read ports.
module ipc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/core/ipc_seq.sv -----
// Sweep sequencer: table clear pass, then the (k, s) accumulate walk.
module ipc_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ipc_pkg::num_t     n_in,
  output logic              busy,
  output ipc_pkg::seq_step_t step
);
  import ipc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CLEAR, S_ACC} state_t;

  state_t state;
  num_t   n;
  num_t   k;
  num_t   s;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n     <= n_in;
            s     <= '0;
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (s == n) begin
            k     <= NUM_W'(1);
            s     <= NUM_W'(1);
            state <= S_ACC;
          end else begin
            s <= s + NUM_W'(1);
          end
        end
        S_ACC: begin
          if (s == n) begin
            if (k == n) begin
              state <= S_IDLE;
            end else begin
              k <= k + NUM_W'(1);
              s <= k + NUM_W'(1);
            end
          end else begin
            s <= s + NUM_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    busy          = (state != S_IDLE);
    step.clr_we   = (state == S_CLEAR);
    step.clr_one  = (s == '0);
    step.clr_addr = s;
    step.issue    = (state == S_ACC);
    step.last     = (state == S_ACC) && (k == n) && (s == n);
    step.ra       = s;
    step.rb       = s - k;
  end

endmodule

// ----- rtl/core/integer_partition_counter.sv -----
// Integer partition counter top level: request intake, add pipeline, result register.
//
// Request channel: cube_count with req_valid / req_stall. Response channel:
// partition_count with rsp_valid / rsp_stall. One response per request.
// n above MAX_N is clamped to MAX_N; n = 0 answers 1.
// Per request the table is cleared (entry 0 to 1, entries 1..n to 0), then
// n(n+1)/2 read-add-write steps run, one per cycle, through the dual-read
// table RAM; the final sum goes from the registered read through the adder
// into the result register. One request is in work at a time.
// The result moves into the output register as soon as it is free, after which
// req_stall drops, so the next request may enter while a response waits.
// A stalled response holds its value until taken.
// Reset (rst, synchronous) empties the pipeline and the output register; the
// table needs no clearing since each request rewrites it before reading.
// Counts saturate at 2^50 - 1.
module integer_partition_counter #(
  parameter int MAX_N = ipc_pkg::MAX_N_DFLT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [8:0]           cube_count,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [49:0]          partition_count
);
  import ipc_pkg::*;

  localparam int DEPTH = MAX_N + 1;
  localparam int AW    = $clog2(DEPTH);

  seq_step_t step;
  logic      seq_busy;
  logic      accept;
  logic      start;
  num_t      n_clamp;

  logic      we;
  num_t      waddr;
  count_t    wdata;
  count_t    rdata_a;
  count_t    rdata_b;

  logic      p_valid;
  logic      p_last;
  num_t      p_addr;
  logic      fa;
  logic      fb;
  count_t    fwd;
  count_t    opa;
  count_t    opb;
  logic [COUNT_W:0] sum_wide;
  count_t    sum;

  logic      res_pend;
  count_t    res;
  logic      move;

  assign n_clamp   = (cube_count > NUM_W'(MAX_N)) ? NUM_W'(MAX_N) : cube_count;
  assign req_stall = seq_busy | p_valid | res_pend;
  assign accept    = req_valid & ~req_stall;
  assign start     = accept & (n_clamp != '0);

  ipc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .n_in  (n_clamp),
    .busy  (seq_busy),
    .step  (step)
  );

  assign we    = step.clr_we | p_valid;
  assign waddr = step.clr_we ? step.clr_addr : p_addr;
  assign wdata = step.clr_we ? COUNT_W'(step.clr_one) : sum;

  ipc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr[AW-1:0]),
    .wdata   (wdata),
    .raddr_a (step.ra[AW-1:0]),
    .raddr_b (step.rb[AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // write in the issue cycle is not yet visible to the read; forward it
  assign opa      = fa ? fwd : rdata_a;
  assign opb      = fb ? fwd : rdata_b;
  assign sum_wide = {1'b0, opa} + {1'b0, opb};
  assign sum      = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_last  <= 1'b0;
    end else begin
      p_valid <= step.issue;
      p_last  <= step.last;
    end
    p_addr <= step.ra;
    fa     <= we && (waddr == step.ra);
    fb     <= we && (waddr == step.rb);
    fwd    <= wdata;
  end

  assign move = res_pend & (~rsp_valid | ~rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_pend  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept && (n_clamp == '0)) begin
        res_pend <= 1'b1;
        res      <= COUNT_W'(1);
      end else if (p_valid && p_last) begin
        res_pend <= 1'b1;
        res      <= sum;
      end else if (move) begin
        res_pend <= 1'b0;
      end
      if (move) begin
        rsp_valid       <= 1'b1;
        partition_count <= res;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(step.clr_we && p_valid))
    else $error("clear write and accumulate write in the same cycle");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!seq_busy && !p_valid && !res_pend))
    else $error("request taken while a previous one is in work");

  a_last_to_result: assert property (@(posedge clk) disable iff (rst)
    (p_valid && p_last) |=> res_pend)
    else $error("final step did not produce a pending result");

  a_issue_order: assert property (@(posedge clk) disable iff (rst)
    step.issue |-> (step.rb < step.ra))
    else $error("accumulate read of s-k not below s");
`endif

endmodule
